[src/sgsc_pkg.sv]
// ----------------------------------------------------------------------------
// sgsc_pkg
// Shared types and constants for the grid separation check block.
// ----------------------------------------------------------------------------
package sgsc_pkg;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_NORMAL  = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // register indexes
   localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] REG_WORLD_WIDTH  = 3'd2;
   localparam logic [2:0] REG_WORLD_HEIGHT = 3'd3;
   localparam logic [2:0] REG_CELL_SIZE    = 3'd4;

   // register reset values
   localparam logic [30:0] WORLD_RESET = 31'd16384;
   localparam logic [30:0] CELL_RESET  = 31'd256;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture request fields
      logic div_start;   // start the cell and grid divisions
      logic locate;      // register cell coordinates and grid size
      logic nb_start;    // reset neighbour offset
      logic nb_next;     // advance neighbour offset
      logic slot_clear;  // reset slot index within bucket
      logic slot_next;   // advance slot index
      logic cnt_read;    // issue count read of current cell
      logic store_read;  // issue sample read
      logic dist_calc;   // register squared distance
      logic dist_check;  // compare distance against threshold
      logic ins_write;   // write sample and bump count
      logic finish;      // load result register
   } ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_busy;
      logic is_query;
      logic ins_outside;
      logic ins_full;
      logic nb_valid;    // current neighbour cell lies in the grid
      logic nb_last;     // last of the nine offsets
      logic slot_done;   // slot index reached cell count
      logic near;        // a point closer than threshold was found
   } stat_type;

endpackage

[src/sgsc_divider.sv]
// ----------------------------------------------------------------------------
// sgsc_divider
// Restoring divider, one quotient bit per cycle, 31 bit unsigned operands.
// ----------------------------------------------------------------------------
module sgsc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,
   input  logic [30:0] divisor,
   output logic        busy,
   output logic [30:0] quotient
);

   logic [30:0] quo_ff, quo_in;
   logic [30:0] rem_ff, rem_in;
   logic [30:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [31:0] trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[30]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 5'd30;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 31'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[29:0], 1'b1};
         end else begin
            rem_in = trial[30:0];
            quo_in = {quo_ff[29:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end
         cnt_in = 5'(cnt_ff - 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[src/sgsc_datapath.sv]
// ----------------------------------------------------------------------------
// sgsc_datapath
// Request registers, cell location, bucket memories and distance unit.
// ----------------------------------------------------------------------------
module sgsc_datapath #(
   parameter int MAX_COLS      = 64,
   parameter int MAX_ROWS      = 64,
   parameter int CELL_CAPACITY = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  sgsc_pkg::ctrl_type  ctrl,
   output sgsc_pkg::stat_type  stat,
   output logic                clear_busy,
   input  logic                req_type,
   input  logic signed [31:0]  point_x,
   input  logic signed [31:0]  point_y,
   input  logic [61:0]         min_dist_sq,
   input  logic signed [31:0]  origin_x,
   input  logic signed [31:0]  origin_y,
   input  logic [30:0]         world_width,
   input  logic [30:0]         world_height,
   input  logic [30:0]         cell_size,
   output logic                res_ok,
   output logic [1:0]          res_status
);

   localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int IW     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SW     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
   localparam int NW     = $clog2(CELL_CAPACITY + 1);
   localparam int AW     = IW + SW;
   localparam int DEPTH  = CELLS * CELL_CAPACITY;

   // request registers
   logic              qry_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [61:0]       thr_ff;
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         qry_ff <= req_type;
         px_ff  <= point_x;
         py_ff  <= point_y;
         thr_ff <= min_dist_sq;
      end
   end

   // offset from origin and world test
   logic signed [32:0] dx, dy;
   logic               in_world;
   logic [30:0]        eff_cell;
   assign dx = 33'(px_ff) - 33'(origin_x);
   assign dy = 33'(py_ff) - 33'(origin_y);
   assign eff_cell = (cell_size == '0) ? 31'd1 : cell_size;
   assign in_world = !dx[32] && !dy[32] && (dx < $signed({2'b00, world_width}))
                  && (dy < $signed({2'b00, world_height}));

   // four parallel divisions sharing start and divisor: cell column, cell row, grid columns, grid rows
   logic        dv_busy [4];
   logic [30:0] dv_quo  [4];
   logic [30:0] dv_num  [4];
   assign dv_num[0] = in_world ? dx[30:0] : '0;
   assign dv_num[1] = in_world ? dy[30:0] : '0;
   assign dv_num[2] = world_width;
   assign dv_num[3] = world_height;
   for (genvar g = 0; g < 4; g++) begin : g_div
      sgsc_divider u_div (
         .clock(clock), .reset(reset), .start(ctrl.div_start),
         .dividend(dv_num[g]), .divisor(eff_cell),
         .busy(dv_busy[g]), .quotient(dv_quo[g])
      );
   end

   // located cell and grid size
   logic [30:0] cx_ff, cy_ff;
   logic [10:0] cols_ff, rows_ff;
   logic [10:0] cols_in, rows_in;
   always_comb begin
      cols_in = (dv_quo[2] == '0) ? 11'd1
              : (dv_quo[2] > 31'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(dv_quo[2]);
      rows_in = (dv_quo[3] == '0) ? 11'd1
              : (dv_quo[3] > 31'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(dv_quo[3]);
   end
   always_ff @(posedge clock) begin
      if (ctrl.locate) begin
         cx_ff   <= dv_quo[0];
         cy_ff   <= dv_quo[1];
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // neighbour walk: offsets -1..1 encoded 0..2, insert uses centre
   logic [1:0] ox_ff, oy_ff;
   always_ff @(posedge clock) begin
      if (ctrl.nb_start) begin
         ox_ff <= qry_ff ? 2'd0 : 2'd1;
         oy_ff <= qry_ff ? 2'd0 : 2'd1;
      end else if (ctrl.nb_next) begin
         if (oy_ff == 2'd2) begin
            oy_ff <= 2'd0;
            ox_ff <= 2'(ox_ff + 2'd1);
         end else begin
            oy_ff <= 2'(oy_ff + 2'd1);
         end
      end
   end

   logic signed [32:0] nx, ny;
   logic               nb_valid;
   logic [IW-1:0]      nb_idx;
   assign nx = $signed({2'b00, cx_ff}) + 33'(ox_ff) - 33'sd1;
   assign ny = $signed({2'b00, cy_ff}) + 33'(oy_ff) - 33'sd1;
   assign nb_valid = !nx[32] && !ny[32] && (nx < $signed({22'd0, cols_ff}))
                  && (ny < $signed({22'd0, rows_ff}));
   assign nb_idx = IW'(nx[CW-1:0] * MAX_ROWS + ny[RW-1:0]);

   // count memory with clearing pass after reset
   logic [NW-1:0] cnt_mem [CELLS];
   logic [NW-1:0] cnt_rd_ff;
   logic [IW-1:0] cur_idx_ff;
   logic [IW:0]   clr_ff;
   logic          clr_busy_ff;
   logic [SW:0]   slot_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_ff <= (IW+1)'(clr_ff + 1'b1);
         if (clr_ff == (IW+1)'(CELLS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         cnt_mem[clr_ff[IW-1:0]] <= '0;
      end else if (ctrl.ins_write) begin
         cnt_mem[cur_idx_ff] <= NW'(cnt_rd_ff + 1'b1);
      end
      if (ctrl.cnt_read) begin
         cnt_rd_ff  <= cnt_mem[nb_idx];
         cur_idx_ff <= nb_idx;
      end
   end

   // sample memory
   logic [63:0]   smp_mem [DEPTH];
   logic [63:0]   smp_rd_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   assign wr_addr = AW'(cur_idx_ff * CELL_CAPACITY + cnt_rd_ff);
   assign rd_addr = AW'(cur_idx_ff * CELL_CAPACITY + slot_ff[SW-1:0]);
   always_ff @(posedge clock) begin
      if (ctrl.ins_write) begin
         smp_mem[wr_addr] <= {py_ff, px_ff};
      end
      if (ctrl.store_read) begin
         smp_rd_ff <= smp_mem[rd_addr];
      end
   end

   // slot index within bucket
   always_ff @(posedge clock) begin
      if (ctrl.slot_clear) begin
         slot_ff <= '0;
      end else if (ctrl.slot_next) begin
         slot_ff <= (SW+1)'(slot_ff + 1'b1);
      end
   end

   // distance: differences and squares in one registered stage
   logic signed [32:0] ddx, ddy;
   logic [32:0]        ax, ay;
   logic [61:0]        sqx_ff, sqy_ff;
   logic               huge_ff;
   assign ddx = 33'($signed(smp_rd_ff[31:0])) - 33'(px_ff);
   assign ddy = 33'($signed(smp_rd_ff[63:32])) - 33'(py_ff);
   assign ax  = ddx[32] ? 33'(-ddx) : 33'(ddx);
   assign ay  = ddy[32] ? 33'(-ddy) : 33'(ddy);
   always_ff @(posedge clock) begin
      if (ctrl.dist_calc) begin
         huge_ff <= ax[32] || ax[31] || ay[32] || ay[31];
         sqx_ff  <= 62'(ax[30:0] * ax[30:0]);
         sqy_ff  <= 62'(ay[30:0] * ay[30:0]);
      end
   end

   // threshold check accumulates a near flag
   logic [62:0] d2;
   logic        near_ff;
   assign d2 = 63'(sqx_ff) + 63'(sqy_ff);
   always_ff @(posedge clock) begin
      if (reset || ctrl.load) begin
         near_ff <= 1'b0;
      end else if (ctrl.dist_check && !huge_ff && (d2 < 63'(thr_ff))) begin
         near_ff <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         if (qry_ff) begin
            res_ok     <= !near_ff;
            res_status <= sgsc_pkg::STATUS_NORMAL;
         end else if (!nb_valid) begin
            res_ok     <= 1'b0;
            res_status <= sgsc_pkg::STATUS_OUTSIDE;
         end else if (cnt_rd_ff >= NW'(CELL_CAPACITY)) begin
            res_ok     <= 1'b0;
            res_status <= sgsc_pkg::STATUS_FULL;
         end else begin
            res_ok     <= 1'b1;
            res_status <= sgsc_pkg::STATUS_NORMAL;
         end
      end
   end

   assign stat.div_busy    = dv_busy[0] || dv_busy[1] || dv_busy[2] || dv_busy[3];
   assign stat.is_query    = qry_ff;
   assign stat.ins_outside = !nb_valid;
   assign stat.ins_full    = cnt_rd_ff >= NW'(CELL_CAPACITY);
   assign stat.nb_valid    = nb_valid;
   assign stat.nb_last     = (ox_ff == 2'd2) && (oy_ff == 2'd2);
   assign stat.slot_done   = slot_ff >= (SW+1)'(cnt_rd_ff);
   assign stat.near        = near_ff;
   assign clear_busy       = clr_busy_ff;

endmodule

[src/sgsc_controller.sv]
// ----------------------------------------------------------------------------
// sgsc_controller
// Sequencer for locate, insert and neighbour scan.
// ----------------------------------------------------------------------------
module sgsc_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               clear_busy,
   input  sgsc_pkg::stat_type stat,
   output sgsc_pkg::ctrl_type ctrl
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_DIV    = 11'b00000000010,
      ST_WAIT   = 11'b00000000100,
      ST_CELL   = 11'b00000001000,
      ST_CNT    = 11'b00000010000,
      ST_SLOT   = 11'b00000100000,
      ST_RDATA  = 11'b00001000000,
      ST_DIST   = 11'b00010000000,
      ST_CHECK  = 11'b00100000000,
      ST_DONE   = 11'b01000000000,
      ST_RESP   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy
                   && (!rsp_valid_ff || rsp_ready);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               ctrl.load = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            ctrl.div_start = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (!stat.div_busy) begin
               ctrl.locate   = 1'b1;
               state_in      = ST_CELL;
            end
         end
         ST_CELL: begin
            ctrl.nb_start = 1'b1;
            state_in      = ST_CNT;
         end
         ST_CNT: begin
            ctrl.cnt_read   = 1'b1;
            ctrl.slot_clear = 1'b1;
            state_in        = stat.is_query ? ST_SLOT : ST_DONE;
         end
         ST_SLOT: begin
            if (!stat.nb_valid || stat.slot_done || stat.near) begin
               if (stat.nb_last || stat.near) begin
                  state_in = ST_DONE;
               end else begin
                  ctrl.nb_next = 1'b1;
                  state_in     = ST_CNT;
               end
            end else begin
               ctrl.store_read = 1'b1;
               state_in        = ST_RDATA;
            end
         end
         ST_RDATA: begin
            ctrl.dist_calc = 1'b1;
            state_in       = ST_DIST;
         end
         ST_DIST: begin
            ctrl.dist_check = 1'b1;
            ctrl.slot_next  = 1'b1;
            state_in        = ST_SLOT;
         end
         ST_CHECK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            ctrl.finish = 1'b1;
            if (!stat.is_query && !stat.ins_outside && !stat.ins_full) begin
               ctrl.ins_write = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/spatial_grid_separation_check.sv]
// ----------------------------------------------------------------------------
// spatial_grid_separation_check
// Uniform grid of point buckets with insert and 3x3 separation query.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset a clearing pass walks the
// bucket count memory before the first request is taken. An insert's result
// is dominated by the 31 step dividers that find the cell and the grid size.
// A query walks all nine neighbour positions, each with a count read and a
// bucket end test, plus a pass through the sample memory port and the
// distance unit for each stored sample, stopping at the first sample nearer
// than the threshold. A finished result blocks the input until it transfers;
// the next request can be taken in the same cycle as that transfer.
module spatial_grid_separation_check #(
   parameter int MAX_COLS      = 64,
   parameter int MAX_ROWS      = 64,
   parameter int CELL_CAPACITY = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic [61:0]        req_min_dist_sq,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   sgsc_pkg::ctrl_type ctrl;
   sgsc_pkg::stat_type stat;
   logic               clear_busy;

   // configuration registers
   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [30:0]        world_w_ff, world_h_ff, cell_ff;
   logic               wr_en;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         world_w_ff  <= sgsc_pkg::WORLD_RESET;
         world_h_ff  <= sgsc_pkg::WORLD_RESET;
         cell_ff     <= sgsc_pkg::CELL_RESET;
      end else if (wr_en) begin
         case (csr_paddr[4:2])
            sgsc_pkg::REG_ORIGIN_X:     origin_x_ff <= csr_pwdata;
            sgsc_pkg::REG_ORIGIN_Y:     origin_y_ff <= csr_pwdata;
            sgsc_pkg::REG_WORLD_WIDTH:  world_w_ff  <= csr_pwdata[30:0];
            sgsc_pkg::REG_WORLD_HEIGHT: world_h_ff  <= csr_pwdata[30:0];
            sgsc_pkg::REG_CELL_SIZE:    cell_ff     <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[4:2])
         sgsc_pkg::REG_ORIGIN_X:     csr_prdata = origin_x_ff;
         sgsc_pkg::REG_ORIGIN_Y:     csr_prdata = origin_y_ff;
         sgsc_pkg::REG_WORLD_WIDTH:  csr_prdata = {1'b0, world_w_ff};
         sgsc_pkg::REG_WORLD_HEIGHT: csr_prdata = {1'b0, world_h_ff};
         sgsc_pkg::REG_CELL_SIZE:    csr_prdata = {1'b0, cell_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   sgsc_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .clear_busy(clear_busy), .stat(stat), .ctrl(ctrl)
   );

   sgsc_datapath #(
      .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .CELL_CAPACITY(CELL_CAPACITY)
   ) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .clear_busy(clear_busy),
      .req_type(req_type), .point_x(req_point_x), .point_y(req_point_y),
      .min_dist_sq(req_min_dist_sq),
      .origin_x(origin_x_ff), .origin_y(origin_y_ff),
      .world_width(world_w_ff), .world_height(world_h_ff), .cell_size(cell_ff),
      .res_ok(rsp_ok), .res_status(rsp_status)
   );

   // no request is taken during the count clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("request accepted during clearing pass");

   // a query never reports a nonzero status
   a_query_status: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish && stat.is_query |=> rsp_status == sgsc_pkg::STATUS_NORMAL)
      else $error("query result with nonzero status");

   // a sample write only happens for an insert that fits
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_write |-> !stat.is_query && !stat.ins_full && !stat.ins_outside)
      else $error("illegal sample write");

endmodule

[tb/spatial_grid_separation_check_tb.sv]
// ----------------------------------------------------------------------------
// spatial_grid_separation_check_tb
// Drives point inserts and separation queries through several grid settings,
// keeps its own copy of the buckets to work out every expected ok/status
// pair, and compares each result transfer against the oldest expectation.
// ----------------------------------------------------------------------------
module spatial_grid_separation_check_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCOLS = 64;
   localparam int NROWS = 64;
   localparam int CAP   = 8;

   typedef struct {
      logic               kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [61:0]        thr;
   } point_req_type;

   typedef struct {
      logic       ok;
      logic [1:0] status;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = sgsc_pkg::REQ_INSERT;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic [61:0]        req_min_dist_sq = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_ok;
   logic [1:0]         rsp_status;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [4:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   spatial_grid_separation_check dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of registers and buckets
   longint   grid_org_x = 0;
   longint   grid_org_y = 0;
   longint   grid_w     = 16384;
   longint   grid_h     = 16384;
   longint   grid_cell  = 256;
   int       bucket_fill [NCOLS*NROWS];
   int       bucket_x    [NCOLS*NROWS*CAP];
   int       bucket_y    [NCOLS*NROWS*CAP];

   point_req_type pending_points[$];
   outcome_type   expected_outcomes[$];
   point_req_type anchors[$];

   int  errors = 0;
   bit  req_taken = 0;
   bit  rsp_taken = 0;
   int  send_gap = 0;
   int  send_gap_max = 6;
   int  recv_stall = 0;
   int  recv_stall_max = 6;
   int  recv_hold = 0;
   bit  long_hold_req = 0;

   // work out the result of one request and update the bucket shadow
   function automatic outcome_type grid_outcome(point_req_type r);
      outcome_type o;
      longint cs, cols, rows, dx, dy, cx, cy, nx, ny, ax, ay, d2, idx;
      longint px, py;
      px = longint'(r.x);
      py = longint'(r.y);
      cs = (grid_cell == 0) ? 1 : grid_cell;
      cols = grid_w / cs;
      rows = grid_h / cs;
      if (cols < 1) cols = 1;
      if (cols > NCOLS) cols = NCOLS;
      if (rows < 1) rows = 1;
      if (rows > NROWS) rows = NROWS;
      dx = px - grid_org_x;
      dy = py - grid_org_y;
      if (dx < 0 || dy < 0 || dx >= grid_w || dy >= grid_h) begin
         cx = 0;
         cy = 0;
      end else begin
         cx = dx / cs;
         cy = dy / cs;
      end
      o.ok = 1'b1;
      o.status = sgsc_pkg::STATUS_NORMAL;
      if (r.kind == sgsc_pkg::REQ_INSERT) begin
         if (cx >= cols || cy >= rows) begin
            o.ok = 1'b0;
            o.status = sgsc_pkg::STATUS_OUTSIDE;
         end else begin
            idx = cx * NROWS + cy;
            if (bucket_fill[idx] >= CAP) begin
               o.ok = 1'b0;
               o.status = sgsc_pkg::STATUS_FULL;
            end else begin
               bucket_x[idx*CAP + bucket_fill[idx]] = r.x;
               bucket_y[idx*CAP + bucket_fill[idx]] = r.y;
               bucket_fill[idx]++;
            end
         end
      end else begin
         for (int ox = -1; ox <= 1; ox++)
            for (int oy = -1; oy <= 1; oy++) begin
               nx = cx + ox;
               ny = cy + oy;
               if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
               idx = nx * NROWS + ny;
               for (int k = 0; k < bucket_fill[idx]; k++) begin
                  ax = longint'(bucket_x[idx*CAP + k]) - px;
                  ay = longint'(bucket_y[idx*CAP + k]) - py;
                  if (ax < 0) ax = -ax;
                  if (ay < 0) ay = -ay;
                  // differences of 2^31 or more are always far
                  if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) continue;
                  d2 = ax * ax + ay * ay;
                  if (d2 < longint'({2'b00, r.thr})) o.ok = 1'b0;
               end
            end
      end
      return o;
   endfunction

   // request driver
   always @(negedge clock) begin
      point_req_type it;
      if (!req_valid || req_taken) begin
         req_taken = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            it = pending_points.pop_front();
            req_type        <= it.kind;
            req_point_x     <= it.x;
            req_point_y     <= it.y;
            req_min_dist_sq <= it.thr;
            req_valid       <= 1'b1;
            send_gap = $urandom_range(0, send_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls and an occasional long hold
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 0;
         recv_hold = 400;
      end
      if (rsp_taken) begin
         rsp_taken = 0;
         recv_stall = $urandom_range(0, recv_stall_max);
      end
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on request transfer, check on result transfer
   always @(posedge clock) begin
      point_req_type r;
      outcome_type   e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1;
            r.kind = req_type;
            r.x    = req_point_x;
            r.y    = req_point_y;
            r.thr  = req_min_dist_sq;
            expected_outcomes.insert(expected_outcomes.size(), grid_outcome(r));
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1;
            if (expected_outcomes.size() == 0) begin
               $error("result transfer with no request outstanding");
               errors++;
            end else begin
               e = expected_outcomes.pop_front();
               if (rsp_ok !== e.ok) begin
                  $error("ok: expected %0d, got %0d", e.ok, rsp_ok);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  errors++;
               end
            end
         end
      end
   end

   // register write: setup cycle then access cycle
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         sgsc_pkg::REG_ORIGIN_X:     grid_org_x = longint'(signed'(val));
         sgsc_pkg::REG_ORIGIN_Y:     grid_org_y = longint'(signed'(val));
         sgsc_pkg::REG_WORLD_WIDTH:  grid_w = longint'(val[30:0]);
         sgsc_pkg::REG_WORLD_HEIGHT: grid_h = longint'(val[30:0]);
         sgsc_pkg::REG_CELL_SIZE:    grid_cell = longint'(val[30:0]);
         default: ;
      endcase
   endtask

   task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] w,
                           logic [31:0] h, logic [31:0] cs);
      csr_write(sgsc_pkg::REG_ORIGIN_X, ox);
      csr_write(sgsc_pkg::REG_ORIGIN_Y, oy);
      csr_write(sgsc_pkg::REG_WORLD_WIDTH, w);
      csr_write(sgsc_pkg::REG_WORLD_HEIGHT, h);
      csr_write(sgsc_pkg::REG_CELL_SIZE, cs);
   endtask

   // block until every queued request has produced its result
   task automatic wait_drained();
      while (pending_points.size() > 0 || req_valid || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic queue_point(logic kind, longint x, longint y, logic [61:0] thr);
      point_req_type r;
      r.kind = kind;
      r.x    = x[31:0];
      r.y    = y[31:0];
      r.thr  = thr;
      pending_points.insert(pending_points.size(), r);
      if (kind == sgsc_pkg::REQ_INSERT) begin
         anchors.insert(anchors.size(), r);
         if (anchors.size() > 32) void'(anchors.pop_front());
      end
   endtask

   // random request: half of them clustered around earlier points
   task automatic queue_random();
      longint cs, x, y, r;
      logic [61:0] thr;
      int mode;
      point_req_type a;
      cs = (grid_cell == 0) ? 1 : grid_cell;
      mode = $urandom_range(0, 9);
      if (mode < 5 && anchors.size() > 0) begin
         a = anchors[$urandom_range(0, anchors.size() - 1)];
         x = longint'(a.x) + longint'($urandom_range(0, 2 * cs)) - cs;
         y = longint'(a.y) + longint'($urandom_range(0, 2 * cs)) - cs;
      end else if (mode < 8) begin
         x = grid_org_x + longint'($urandom_range(0, grid_w - 1));
         y = grid_org_y + longint'($urandom_range(0, grid_h - 1));
      end else begin
         x = longint'($urandom);
         y = longint'($urandom);
      end
      mode = $urandom_range(0, 9);
      if (mode == 0) thr = '0;
      else if (mode == 1) thr = '1;
      else if (mode < 4) thr = {$urandom, $urandom};
      else begin
         r = $urandom_range(0, 2 * cs);
         thr = r * r;
      end
      queue_point($urandom_range(0, 1), x, y, thr);
   endtask

   task automatic run_random(int n);
      repeat (n) queue_random();
      wait_drained();
   endtask

   // stimulus
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part at reset settings
      queue_point(sgsc_pkg::REQ_INSERT, 0, 0, '1);
      queue_point(sgsc_pkg::REQ_INSERT, 255, 255, '0);
      queue_point(sgsc_pkg::REQ_QUERY, 0, 0, '0);
      queue_point(sgsc_pkg::REQ_QUERY, 1, 0, 62'd2);
      queue_point(sgsc_pkg::REQ_QUERY, 1, 0, 62'd1);
      repeat (8) queue_point(sgsc_pkg::REQ_INSERT, 10, 10, '0);
      queue_point(sgsc_pkg::REQ_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, '0);
      queue_point(sgsc_pkg::REQ_QUERY, -64'sd2147483648, -64'sd2147483648, '1);
      queue_point(sgsc_pkg::REQ_QUERY, 16383, 16383, '1);
      queue_point(sgsc_pkg::REQ_INSERT, 16383, 16383, '1);
      queue_point(sgsc_pkg::REQ_QUERY, 16128, 16128, '1);
      queue_point(sgsc_pkg::REQ_QUERY, 16128, 16128, 62'd1);
      queue_point(sgsc_pkg::REQ_QUERY, 256, 256, '1);
      wait_drained();

      // small 8x8 grid around a negative origin
      set_grid(-2048, -2048, 4096, 4096, 512);
      run_random(200);

      // no idling stretch
      send_gap_max = 0;
      recv_stall_max = 0;
      run_random(60);
      send_gap_max = 6;
      recv_stall_max = 6;

      // finest cells, widest world, most negative origin
      set_grid(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1);
      run_random(120);

      // one huge cell at the most positive origin
      set_grid(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff);
      run_random(100);

      // saturated columns with few rows, inserts past the grid
      set_grid(0, 0, 16384, 300, 100);
      run_random(120);

      // zero cell size with the smallest world
      set_grid(5, -5, 1, 1, 0);
      run_random(60);

      // back to reset settings: long receiver hold while requests keep coming
      set_grid(0, 0, sgsc_pkg::WORLD_RESET, sgsc_pkg::WORLD_RESET, sgsc_pkg::CELL_RESET);
      repeat (60) queue_random();
      long_hold_req = 1;
      run_random(80);
      // a further random batch once all earlier results are in
      run_random(40);

      wait_drained();
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
